### rtl/running_mean_variance_macros.svh
// assertion macros for the running mean and variance block
// no dependencies; included by the files that carry assertions
`ifndef RUNNING_MEAN_VARIANCE_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RMV_ASSERT_IMPL(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("running_mean_variance: assertion failed");

// next-cycle implication, disabled while in reset
`define RMV_ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("running_mean_variance: assertion failed");

`endif

### rtl/rmv_pkg.sv
// shared widths, constants, item codes and the request type of the shared adder
// no dependencies; compiled before every other file of the block
`default_nettype none

package rmv_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int COUNT_BITS  = 16;

  localparam int MEAN_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int DIFF_BITS = MEAN_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int SCL_BITS  = PROD_BITS - FRAC_BITS;
  localparam int SUM_BITS  = 64;
  localparam int VAR_BITS  = 47;
  localparam int STD_BITS  = 24;
  localparam int OCNT_BITS = 16;
  localparam int ALU_BITS  = PROD_BITS;
  localparam int STEP_BITS = $clog2(SUM_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SUM_BITS-1:0]   VAR_MAX   = SUM_BITS'(64'h0000_4000_0000_0000);

  // func field of an input item
  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_PUSH  = 1'b1
  } op_t;

  typedef struct packed {
    logic [ALU_BITS-1:0] a;
    logic [ALU_BITS-1:0] b;
    logic                sub;
  } alu_req_t;

endpackage

`default_nettype wire

### rtl/rmv_if.sv
// valid/ready channel interfaces for samples in and statistics out
// depends on rmv_pkg for field widths
`default_nettype none

interface rmv_in_if import rmv_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink (input valid, input func, input sample, output ready);
endinterface

interface rmv_out_if import rmv_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OCNT_BITS-1:0]        sample_count;
  logic signed [MEAN_BITS-1:0] mean_value;
  logic [VAR_BITS-1:0]         variance_value;
  logic [STD_BITS-1:0]         std_deviation;
  logic                        saturated;

  modport source (output valid, output sample_count, output mean_value,
                  output variance_value, output std_deviation, output saturated,
                  input ready);
  modport sink (input valid, input sample_count, input mean_value,
                input variance_value, input std_deviation, input saturated,
                output ready);
endinterface

`default_nettype wire

### rtl/rmv_alu.sv
// shared add/subtract unit used by every iterative step of the block
// depends on rmv_pkg; carry out set on subtract means a >= b
`default_nettype none

module rmv_alu import rmv_pkg::*; (
  input  alu_req_t            req,
  output logic [ALU_BITS:0]   y
);

  logic [ALU_BITS-1:0] b_op;

  assign b_op = req.sub ? ~req.b : req.b;
  assign y    = {1'b0, req.a} + {1'b0, b_op} + (ALU_BITS + 1)'(req.sub);

endmodule

`default_nettype wire

### rtl/running_mean_variance.sv
// running mean / variance / deviation of a sample stream, top level
// depends on rmv_pkg, rmv_if, rmv_alu and running_mean_variance_macros.svh
//
// in_ch carries func (0 clears the statistics, 1 pushes a sample) and a
// signed sample; every transfer on in_ch yields exactly one transfer on
// out_ch with the count, Q16 mean, Q16 unbiased variance, Q8 deviation
// and the sticky saturation flag.
// in_ch.ready is high only while the sequencer is idle and holds no
// finished result. A clear or the first sample after a clear skips
// the arithmetic and goes straight to its result. Any other push runs
// a 33-step mean divide, a 33-step shift-add multiply, a 64-step
// variance divide and a 24-step square root, all on the one shared
// adder, with setup and load states between them; the next item is
// taken only once the result of the last one is finished.
// Results sit in an output register; a new item can be taken while that
// register waits on out_ch.ready, and the sequencer holds its finished
// result until the register frees up.
// Reset (rst_n low, synchronous) clears count, mean, sum and flag, drops
// out_ch.valid and returns the sequencer to idle.
`default_nettype none
`include "running_mean_variance_macros.svh"

module running_mean_variance import rmv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rmv_in_if.sink      in_ch,
  rmv_out_if.source   out_ch
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DSET = 11'b000_0000_0010,
    S_DIVM = 11'b000_0000_0100,
    S_MEAN = 11'b000_0000_1000,
    S_DEV2 = 11'b000_0001_0000,
    S_MUL  = 11'b000_0010_0000,
    S_SUM  = 11'b000_0100_0000,
    S_VSET = 11'b000_1000_0000,
    S_DIVV = 11'b001_0000_0000,
    S_SSET = 11'b010_0000_0000,
    S_SQRT = 11'b100_0000_0000
  } state_t;

  localparam state_t S_FIN_UNUSED = S_IDLE;

  localparam logic [MEAN_BITS-1:0] MEAN_MAX = {1'b0, {(MEAN_BITS-1){1'b1}}};
  localparam logic [MEAN_BITS-1:0] MEAN_MIN = {1'b1, {(MEAN_BITS-1){1'b0}}};
  localparam logic [VAR_BITS-1:0]  BIT_TOP  = {1'b1, {(VAR_BITS-1){1'b0}}};

  // sequencer and statistics state
  state_t                  state_r, state_nxt;
  logic                    fin_r, fin_nxt;
  logic [COUNT_BITS-1:0]   count_r, count_nxt;
  logic [MEAN_BITS-1:0]    mean_r, mean_nxt;
  logic [SUM_BITS-1:0]     sum_r, sum_nxt;
  logic                    sat_r, sat_nxt;
  logic                    ov_r, ov_nxt;

  // datapath
  logic [MEAN_BITS-1:0]    xq_r, xq_nxt;
  logic [DIFF_BITS-1:0]    d_r, d_nxt;
  logic                    d_neg_r, d_neg_nxt;
  logic                    d_nz_r, d_nz_nxt;
  logic [DIFF_BITS-1:0]    mcand_r, mcand_nxt;
  logic [DIFF_BITS-1:0]    mplier_r, mplier_nxt;
  logic [PROD_BITS-1:0]    acc_r, acc_nxt;
  logic                    neg_r, neg_nxt;
  logic [SUM_BITS-1:0]     dq_r, dq_nxt;
  logic [COUNT_BITS-1:0]   rem_r, rem_nxt;
  logic [COUNT_BITS-1:0]   dv_r, dv_nxt;
  logic [STEP_BITS-1:0]    step_r, step_nxt;
  logic [VAR_BITS-1:0]     var_r, var_nxt;
  logic [VAR_BITS-1:0]     sv_r, sv_nxt;
  logic [VAR_BITS-1:0]     res_r, res_nxt;
  logic [VAR_BITS-1:0]     bit_r, bit_nxt;

  // output register
  logic [OCNT_BITS-1:0]    o_count_r;
  logic [MEAN_BITS-1:0]    o_mean_r;
  logic [VAR_BITS-1:0]     o_var_r;
  logic [STD_BITS-1:0]     o_std_r;
  logic                    o_sat_r;
  logic                    o_load;

  logic                    in_ready, in_fire, out_fire;
  logic [MEAN_BITS-1:0]    xq_in;
  logic [DIFF_BITS-1:0]    d_in, d_mag, d2, d2_mag;
  logic [COUNT_BITS:0]     div_trial;
  logic [DIFF_BITS:0]      q_s, nm;
  logic [MEAN_BITS-1:0]    nm_clamp;
  logic [DIFF_BITS:0]      mul_upper;
  logic [VAR_BITS-1:0]     sq_trial;
  logic [VAR_BITS-1:0]     var_clamp;

  alu_req_t                alu_req;
  logic [ALU_BITS:0]       alu_y;
  logic                    alu_co;

  rmv_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  assign alu_co   = alu_y[ALU_BITS];
  assign in_ready = (state_r == S_IDLE) && !fin_r;
  assign in_fire  = in_ch.valid && in_ready;
  assign out_fire = ov_r && out_ch.ready;
  assign in_ch.ready = in_ready;

  assign out_ch.valid          = ov_r;
  assign out_ch.sample_count   = o_count_r;
  assign out_ch.mean_value     = o_mean_r;
  assign out_ch.variance_value = o_var_r;
  assign out_ch.std_deviation  = o_std_r;
  assign out_ch.saturated      = o_sat_r;

  // sample scaled into the mean's fixed point format
  assign xq_in  = {in_ch.sample, {FRAC_BITS{1'b0}}};
  assign d_in   = {xq_in[MEAN_BITS-1], xq_in} - {mean_r[MEAN_BITS-1], mean_r};
  assign d_mag  = d_r[DIFF_BITS-1] ? (~d_r + DIFF_BITS'(1)) : d_r;
  assign d2     = {xq_r[MEAN_BITS-1], xq_r} - {mean_r[MEAN_BITS-1], mean_r};
  assign d2_mag = d2[DIFF_BITS-1] ? (~d2 + DIFF_BITS'(1)) : d2;

  assign div_trial = {rem_r, dq_r[SUM_BITS-1]};

  // signed quotient added to the old mean, then clamped to 32 bits
  assign q_s = d_neg_r ? (~{1'b0, dq_r[DIFF_BITS-1:0]} + (DIFF_BITS + 1)'(1))
                       : {1'b0, dq_r[DIFF_BITS-1:0]};
  assign nm  = {{2{mean_r[MEAN_BITS-1]}}, mean_r} + q_s;

  always_comb begin
    if (nm[DIFF_BITS:MEAN_BITS-1] == '0 || nm[DIFF_BITS:MEAN_BITS-1] == '1) begin
      nm_clamp = nm[MEAN_BITS-1:0];
    end else if (nm[DIFF_BITS]) begin
      nm_clamp = MEAN_MIN;
    end else begin
      nm_clamp = MEAN_MAX;
    end
  end

  assign mul_upper = mplier_r[0] ? alu_y[DIFF_BITS:0]
                                 : {1'b0, acc_r[PROD_BITS-1:DIFF_BITS]};
  // res and bit never overlap in the digit-by-digit root
  assign sq_trial  = res_r | bit_r;
  assign var_clamp = (dq_r > VAR_MAX) ? VAR_MAX[VAR_BITS-1:0] : dq_r[VAR_BITS-1:0];

  always_comb begin
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    case (state_r)
      S_DIVM, S_DIVV: begin
        alu_req.a   = ALU_BITS'(div_trial);
        alu_req.b   = ALU_BITS'(dv_r);
        alu_req.sub = 1'b1;
      end
      S_MUL: begin
        alu_req.a = ALU_BITS'(acc_r[PROD_BITS-1:DIFF_BITS]);
        alu_req.b = ALU_BITS'(mcand_r);
      end
      S_SUM: begin
        // scaled product fits 50 bits, so only the 64-bit sum can overflow
        alu_req.a   = ALU_BITS'(sum_r);
        alu_req.b   = ALU_BITS'(acc_r[PROD_BITS-1:FRAC_BITS]);
        alu_req.sub = neg_r;
      end
      S_SQRT: begin
        alu_req.a   = ALU_BITS'(sv_r);
        alu_req.b   = ALU_BITS'(sq_trial);
        alu_req.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    count_nxt  = count_r;
    mean_nxt   = mean_r;
    sum_nxt    = sum_r;
    sat_nxt    = sat_r;
    xq_nxt     = xq_r;
    d_nxt      = d_r;
    d_neg_nxt  = d_neg_r;
    d_nz_nxt   = d_nz_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    dq_nxt     = dq_r;
    rem_nxt    = rem_r;
    dv_nxt     = dv_r;
    step_nxt   = step_r;
    var_nxt    = var_r;
    sv_nxt     = sv_r;
    res_nxt    = res_r;
    bit_nxt    = bit_r;
    o_load     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (fin_r) begin
          if (!ov_r || out_ch.ready) begin
            o_load  = 1'b1;
            fin_nxt = 1'b0;
          end
        end else if (in_fire) begin
          if (in_ch.func == OP_CLEAR) begin
            count_nxt = '0;
            mean_nxt  = '0;
            sum_nxt   = '0;
            sat_nxt   = 1'b0;
            state_nxt = S_VSET;
          end else if (count_r == '0) begin
            count_nxt = COUNT_BITS'(1);
            mean_nxt  = xq_in;
            sum_nxt   = '0;
            state_nxt = S_VSET;
          end else begin
            if (count_r == COUNT_MAX) begin
              sat_nxt = 1'b1;
            end else begin
              count_nxt = count_r + COUNT_BITS'(1);
            end
            xq_nxt    = xq_in;
            d_nxt     = d_in;
            state_nxt = S_DSET;
          end
        end
      end
      S_DSET: begin
        dq_nxt    = {d_mag, {(SUM_BITS-DIFF_BITS){1'b0}}};
        rem_nxt   = '0;
        dv_nxt    = count_r;
        step_nxt  = '0;
        mcand_nxt = d_mag;
        d_neg_nxt = d_r[DIFF_BITS-1];
        d_nz_nxt  = (d_r != '0);
        state_nxt = S_DIVM;
      end
      S_DIVM, S_DIVV: begin
        // restoring divide, one quotient bit per cycle
        rem_nxt  = alu_co ? alu_y[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
        dq_nxt   = {dq_r[SUM_BITS-2:0], alu_co};
        step_nxt = step_r + STEP_BITS'(1);
        if (state_r == S_DIVM && step_r == STEP_BITS'(DIFF_BITS - 1)) begin
          state_nxt = S_MEAN;
        end else if (state_r == S_DIVV && step_r == STEP_BITS'(SUM_BITS - 1)) begin
          state_nxt = S_SSET;
        end
      end
      S_MEAN: begin
        mean_nxt  = nm_clamp;
        state_nxt = S_DEV2;
      end
      S_DEV2: begin
        mplier_nxt = d2_mag;
        neg_nxt    = (d_neg_r && !d2[DIFF_BITS-1] && d2 != '0) ||
                     (!d_neg_r && d_nz_r && d2[DIFF_BITS-1]);
        acc_nxt    = '0;
        step_nxt   = '0;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        acc_nxt    = {mul_upper, acc_r[DIFF_BITS-1:1]};
        mplier_nxt = {1'b0, mplier_r[DIFF_BITS-1:1]};
        step_nxt   = step_r + STEP_BITS'(1);
        if (step_r == STEP_BITS'(DIFF_BITS - 1)) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (neg_r) begin
          // subtract floors at zero
          sum_nxt = alu_co ? alu_y[SUM_BITS-1:0] : '0;
        end else if (alu_y[SUM_BITS]) begin
          sum_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          sum_nxt = alu_y[SUM_BITS-1:0];
        end
        state_nxt = S_VSET;
      end
      S_VSET: begin
        if (count_r > COUNT_BITS'(1)) begin
          dq_nxt    = sum_r;
          rem_nxt   = '0;
          dv_nxt    = count_r - COUNT_BITS'(1);
          step_nxt  = '0;
          state_nxt = S_DIVV;
        end else begin
          var_nxt   = '0;
          res_nxt   = '0;
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SSET: begin
        var_nxt   = var_clamp;
        sv_nxt    = var_clamp;
        res_nxt   = '0;
        bit_nxt   = BIT_TOP;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (alu_co) begin
          sv_nxt  = alu_y[VAR_BITS-1:0];
          res_nxt = {1'b0, res_r[VAR_BITS-1:1]} | bit_r;
        end else begin
          res_nxt = {1'b0, res_r[VAR_BITS-1:1]};
        end
        bit_nxt = {2'b00, bit_r[VAR_BITS-1:2]};
        if (bit_r[0]) begin
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        fin_nxt   = 1'b0;
      end
    endcase
  end

  // valid stays until the transfer; a finished result reloads it
  always_comb begin
    ov_nxt = ov_r;
    if (out_fire) begin
      ov_nxt = 1'b0;
    end
    if (o_load) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
      count_r <= '0;
      mean_r  <= '0;
      sum_r   <= '0;
      sat_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      count_r <= count_nxt;
      mean_r  <= mean_nxt;
      sum_r   <= sum_nxt;
      sat_r   <= sat_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xq_r     <= xq_nxt;
    d_r      <= d_nxt;
    d_neg_r  <= d_neg_nxt;
    d_nz_r   <= d_nz_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    neg_r    <= neg_nxt;
    dq_r     <= dq_nxt;
    rem_r    <= rem_nxt;
    dv_r     <= dv_nxt;
    step_r   <= step_nxt;
    var_r    <= var_nxt;
    sv_r     <= sv_nxt;
    res_r    <= res_nxt;
    bit_r    <= bit_nxt;
    if (o_load) begin
      o_count_r <= count_r[OCNT_BITS-1:0];
      o_mean_r  <= mean_r;
      o_var_r   <= var_r;
      o_std_r   <= res_r[STD_BITS-1:0];
      o_sat_r   <= sat_r;
    end
  end

  `RMV_ASSERT_NEXT(a_clear_zeroes, clk, rst_n, in_fire && in_ch.func == OP_CLEAR, count_r == '0 && sum_r == '0 && !sat_r)
  `RMV_ASSERT_NEXT(a_push_count_up, clk, rst_n, in_fire && in_ch.func == OP_PUSH, count_r >= $past(count_r) && count_r != '0)
  `RMV_ASSERT_IMPL(a_few_samples_no_var, clk, rst_n, ov_r && o_count_r < OCNT_BITS'(2), o_var_r == '0 && o_std_r == '0)
  `RMV_ASSERT_NEXT(a_sat_sticky, clk, rst_n, sat_r && !(in_fire && in_ch.func == OP_CLEAR), sat_r)
  `RMV_ASSERT_NEXT(a_result_loads, clk, rst_n, fin_r && !ov_r && state_r == S_FIN_UNUSED, ov_r && !fin_r)

endmodule

`default_nettype wire

### tb/running_mean_variance_tb.sv
// self-checking testbench for running_mean_variance: directed table, then random samples
// depends on rmv_pkg, rmv_if and the running_mean_variance rtl; results checked by a predictor

module running_mean_variance_tb;
  import rmv_pkg::*;

  typedef struct packed {
    logic [OCNT_BITS-1:0] count;
    logic [MEAN_BITS-1:0] mean;
    logic [VAR_BITS-1:0]  variance;
    logic [STD_BITS-1:0]  std_dev;
    logic                 sat;
  } stats_t;

  typedef struct packed {
    op_t                    op;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   typed;
    stats_t                 res;
  } row_t;

  localparam int NUM_ROWS     = 25;
  localparam int NUM_RANDOM   = 500;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam longint MEAN_HI  = (longint'(1) <<< (MEAN_BITS - 1)) - 1;
  localparam longint MEAN_LO  = -(longint'(1) <<< (MEAN_BITS - 1));

  // typed rows hold results worked out by hand, the variance clamp included
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{OP_PUSH,  16'h0064, 1'b1, '{16'd1, 32'h0064_0000, 47'd0, 24'd0, 1'b0}},
    '{OP_PUSH,  16'h0064, 1'b0, '0},
    '{OP_PUSH,  16'h0066, 1'b0, '0},
    '{OP_CLEAR, 16'h0000, 1'b1, '0},
    '{OP_CLEAR, 16'hFFFF, 1'b1, '0},
    '{OP_PUSH,  16'h8000, 1'b1, '{16'd1, 32'h8000_0000, 47'd0, 24'd0, 1'b0}},
    '{OP_PUSH,  16'h7FFF, 1'b1,
      '{16'd2, 32'hFFFF_8000, 47'h4000_0000_0000, 24'h80_0000, 1'b0}},
    '{OP_PUSH,  16'h8000, 1'b0, '0},
    '{OP_PUSH,  16'h7FFF, 1'b0, '0},
    '{OP_PUSH,  16'h0000, 1'b0, '0},
    '{OP_CLEAR, 16'h5A5A, 1'b1, '0},
    '{OP_PUSH,  16'h7FFF, 1'b1, '{16'd1, 32'h7FFF_0000, 47'd0, 24'd0, 1'b0}},
    '{OP_PUSH,  16'h7FFF, 1'b0, '0},
    '{OP_PUSH,  16'h7FFE, 1'b0, '0},
    '{OP_CLEAR, 16'hA5A5, 1'b1, '0},
    '{OP_PUSH,  16'h0000, 1'b1, '{16'd1, 32'h0000_0000, 47'd0, 24'd0, 1'b0}},
    '{OP_PUSH,  16'h0001, 1'b0, '0},
    '{OP_PUSH,  16'h0000, 1'b0, '0},
    '{OP_PUSH,  16'hFFFF, 1'b0, '0},
    '{OP_PUSH,  16'hFFFF, 1'b0, '0},
    '{OP_PUSH,  16'h0001, 1'b0, '0},
    '{OP_CLEAR, 16'h0000, 1'b1, '0},
    '{OP_PUSH,  16'hFFFF, 1'b1, '{16'd1, 32'hFFFF_0000, 47'd0, 24'd0, 1'b0}},
    '{OP_PUSH,  16'h8001, 1'b0, '0},
    '{OP_PUSH,  16'h0000, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  rmv_in_if  in_ch ();
  rmv_out_if out_ch ();

  running_mean_variance DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // running statistics as the block should hold them
  int unsigned acc_count = 0;
  longint      acc_mean  = 0;
  logic [63:0] acc_sum   = '0;
  bit          acc_sat   = 1'b0;

  stats_t      expected_stats [$];
  logic        pinned;
  stats_t      pinned_stats;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned burst_left = 0;

  function automatic longint clamp_mean(longint v);
    if (v > MEAN_HI) return MEAN_HI;
    if (v < MEAN_LO) return MEAN_LO;
    return v;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [STD_BITS-1:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = STD_BITS - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[STD_BITS-1:0];
  endfunction

  // advances the running statistics by one item and returns its result
  function automatic stats_t predict_stats(op_t op, logic [SAMPLE_BITS-1:0] smp);
    logic signed [SAMPLE_BITS-1:0] s;
    longint       xq;
    longint       d;
    longint       d2;
    longint       nm;
    logic [127:0] prod;
    logic [63:0]  scaled;
    logic [64:0]  total;
    logic [63:0]  quot;
    bit           ovf;
    stats_t       r;
    if (op == OP_CLEAR) begin
      acc_count = 0;
      acc_mean  = 0;
      acc_sum   = '0;
      acc_sat   = 1'b0;
    end else begin
      s  = smp;
      xq = longint'(s) * (longint'(1) <<< FRAC_BITS);
      if (acc_count == 0) begin
        acc_count = 1;
        acc_mean  = clamp_mean(xq);
        acc_sum   = '0;
      end else begin
        if (acc_count >= COUNT_MAX) begin
          acc_count = COUNT_MAX;
          acc_sat   = 1'b1;
        end else begin
          acc_count++;
        end
        d  = xq - acc_mean;
        nm = clamp_mean(acc_mean + d / longint'(acc_count));
        d2 = xq - nm;
        acc_mean = nm;
        prod   = {64'd0, magnitude(d)} * {64'd0, magnitude(d2)};
        ovf    = |prod[127:64+FRAC_BITS];
        scaled = ovf ? '1 : prod[64+FRAC_BITS-1:FRAC_BITS];
        // opposite signs only after a mean clamp: the term comes off the sum
        if ((d < 0 && d2 > 0) || (d > 0 && d2 < 0)) begin
          acc_sum = (scaled >= acc_sum) ? '0 : acc_sum - scaled;
        end else begin
          total = {1'b0, acc_sum} + {1'b0, scaled};
          if (ovf || total[64]) begin
            acc_sum = '1;
            acc_sat = 1'b1;
          end else begin
            acc_sum = total[63:0];
          end
        end
      end
    end
    quot = '0;
    if (acc_count > 1) begin
      quot = acc_sum / 64'(acc_count - 1);
      if (quot > VAR_MAX) quot = VAR_MAX;
    end
    r.count    = OCNT_BITS'(acc_count);
    r.mean     = MEAN_BITS'(acc_mean);
    r.variance = quot[VAR_BITS-1:0];
    r.std_dev  = int_sqrt(quot);
    r.sat      = acc_sat;
    return r;
  endfunction

  task automatic report(string field, logic [63:0] want_v, logic [63:0] got_v);
    $display("%0t: %s expected %0h actual %0h", $time, field, want_v, got_v);
    mismatches++;
  endtask

  // one input transfer, then possibly a gap once the current burst runs out
  task automatic transfer_item(op_t op, logic [SAMPLE_BITS-1:0] smp, logic typed,
                               stats_t res);
    int unsigned gap;
    in_ch.valid  <= 1'b1;
    in_ch.func   <= op;
    in_ch.sample <= smp;
    pinned       <= typed;
    pinned_stats <= res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  always @(posedge clk) begin : monitor
    stats_t got;
    stats_t want;
    stats_t predicted;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = predict_stats(op_t'(in_ch.func), in_ch.sample);
        expected_stats.push_back(pinned ? pinned_stats : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.sample_count, out_ch.mean_value, out_ch.variance_value,
                out_ch.std_deviation, out_ch.saturated};
        if (expected_stats.size() == 0) begin
          report("unexpected transfer, count", '0, 64'(got.count));
        end else begin
          want = expected_stats.pop_front();
          if (got.count !== want.count) report("sample_count", want.count, got.count);
          if (got.mean !== want.mean) report("mean_value", want.mean, got.mean);
          if (got.variance !== want.variance)
            report("variance_value", want.variance, got.variance);
          if (got.std_dev !== want.std_dev)
            report("std_deviation", want.std_dev, got.std_dev);
          if (got.sat !== want.sat) report("saturated", want.sat, got.sat);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: an 8-bit ready pattern, each bit held for a random dwell
  initial begin : receiver
    logic [7:0]  pat;
    int unsigned dwell;
    forever begin
      pat   = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      dwell = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(20, 200);
      for (int i = 0; i < 8; i++) begin
        out_ch.ready <= pat[i];
        repeat (dwell) @(posedge clk);
      end
    end
  end

  initial begin : sender
    op_t                    op;
    logic [SAMPLE_BITS-1:0] smp;
    logic [SAMPLE_BITS-1:0] center;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= OP_CLEAR;
    in_ch.sample <= '0;
    pinned       <= 1'b0;
    pinned_stats <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++)
      transfer_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].sample,
                    DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

    // mostly pushes; clusters around a center keep the variance small
    center = 16'($urandom);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_PUSH;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: smp = 16'($urandom);
        4, 5, 6:    smp = center + 16'($urandom_range(0, 15)) - 16'd8;
        7:          smp = ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000;
        8:          smp = 16'($urandom_range(0, 8)) - 16'd4;
        default:    smp = center;
      endcase
      if (op == OP_CLEAR) center = 16'($urandom);
      transfer_item(op, smp, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/rmv_pkg.sv
rtl/rmv_if.sv
rtl/rmv_alu.sv
rtl/running_mean_variance.sv
tb/running_mean_variance_tb.sv
